FILE: rtl/asm_pkg.sv
// Package for the automaton string matcher: widths of the pattern, the
// configuration port and the result fields, plus configuration register codes.
// No dependencies.
package asm_pkg;

  localparam int PAT_BYTES     = 16;  // pattern storage in bytes
  localparam int LEN_W         = 5;   // pattern length and automaton state
  localparam int MATCH_START_W = 16;  // match_start result field
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 2'd0,
    CFG_PAT_HI  = 2'd1,
    CFG_PAT_LEN = 2'd2
  } cfg_idx_e;

  typedef logic [7:0] byte_t;

endpackage

FILE: rtl/automaton_string_matcher.sv
// Automaton string matcher top level: pattern registers, automaton state,
// prefix/suffix compare network and the output register. Uses asm_pkg.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes the
//   pattern: index 0 holds bytes 0..7, index 1 bytes 8..15 (byte 0 in the low
//   bits), index 2 the pattern length (1..16, low 5 bits kept). cfg_ready_o is
//   always high; write only while no item is in flight.
//   in channel (in_valid_i/in_ready_o) carries text_byte_i and text_start_i;
//   text_start_i clears the automaton state and the byte index for that item.
//   out channel (out_valid_o/out_ready_i) returns one result per item:
//   matched_o and match_start_o (start index of the match, 0 if none).
// Timing: out_valid_o rises in the cycle after an input is accepted.
// Throughput: 1 item per cycle while out_ready_i is high; the next state is computed in the accept cycle
//   by parallel compares of pattern prefixes against the shifted pattern.
// Stall: the output register holds its result while out_ready_i is low, and
//   in_ready_o drops until the result is taken.
// Reset: pattern cleared, length 1, state and byte index zero, no result held.
module automaton_string_matcher
  import asm_pkg::*;
#(
  parameter int MAX_PATTERN = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               text_byte_i,
  input  logic                     text_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     matched_o,
  output logic [MATCH_START_W-1:0] match_start_o
);

  localparam logic [INDEX_WIDTH-1:0] IdxMax = {INDEX_WIDTH{1'b1}};

  logic [CFG_DATA_W-1:0]    pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0]         pat_len_q;
  logic [LEN_W-1:0]         prefix_q, prefix_d;
  logic [INDEX_WIDTH-1:0]   idx_q, idx_d;
  logic                     out_valid_q;
  logic                     matched_q, matched_d;
  logic [MATCH_START_W-1:0] match_start_q, match_start_d;

  logic                     in_acc;
  logic [2*CFG_DATA_W-1:0]  pat_all;
  byte_t                    pat [PAT_BYTES];
  logic [PAT_BYTES-1:0]     eqv [PAT_BYTES];   // eqv[s][j]: pat[j] == pat[j+s]
  logic [PAT_BYTES-1:0]     e_tab [PAT_BYTES]; // e_tab[s][m]: prefix m equals run at s
  logic [LEN_W-1:0]         len_act;
  logic [LEN_W-1:0]         q_cur, q_eff, kmax;
  logic [LEN_W-1:0]         s_arr [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]   fits;
  logic [INDEX_WIDTH-1:0]   cur;
  logic [INDEX_WIDTH:0]     cur1, start_w, len_x;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  // Pattern self-compare table, depends on configuration only
  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      pat[i] = pat_all[8*i +: 8];
    end
    for (int s = 0; s < PAT_BYTES; s++) begin
      for (int j = 0; j < PAT_BYTES; j++) begin
        eqv[s][j] = (j + s < PAT_BYTES) ? (pat[j] == pat[(j + s) % PAT_BYTES]) : 1'b0;
      end
      for (int m = 0; m < PAT_BYTES; m++) begin
        e_tab[s][m] = &(eqv[s] | ~((PAT_BYTES'(1) << m) - PAT_BYTES'(1)));
      end
    end
  end

  // Automaton step
  always_comb begin
    if (pat_len_q == '0) begin
      len_act = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
      len_act = LEN_W'(MAX_PATTERN);
    end else begin
      len_act = pat_len_q;
    end

    q_cur = text_start_i ? '0 : prefix_q;
    q_eff = (q_cur > len_act) ? len_act : q_cur;
    kmax  = (q_eff + LEN_W'(1) < len_act) ? q_eff + LEN_W'(1) : len_act;

    // candidate k: last pattern byte matches the new byte, the rest is a border
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      s_arr[k-1] = q_eff + LEN_W'(1) - LEN_W'(k);
      fits[k-1]  = (LEN_W'(k) <= kmax) && (pat[k-1] == text_byte_i) &&
                   ((k == 1) || e_tab[s_arr[k-1][3:0]][(k-1) % PAT_BYTES]);
    end

    prefix_d = '0;
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      if (fits[k-1]) begin
        prefix_d = LEN_W'(k);
      end
    end

    cur   = text_start_i ? '0 : idx_q;
    idx_d = (cur == IdxMax) ? cur : cur + INDEX_WIDTH'(1);
    cur1  = {1'b0, cur} + (INDEX_WIDTH + 1)'(1);
    len_x = (INDEX_WIDTH + 1)'(len_act);
    start_w = (cur1 >= len_x) ? cur1 - len_x : '0;

    matched_d     = (prefix_d == len_act);
    match_start_d = matched_d ? MATCH_START_W'(start_w) : '0;
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        prefix_q    <= prefix_d;
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      matched_q     <= matched_d;
      match_start_q <= match_start_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = matched_q;
  assign match_start_o = match_start_q;

  // Assertions
  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_q <= LEN_W'(MAX_PATTERN))
    else $error("automaton state beyond maximum pattern length");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> match_start_o == '0)
    else $error("match_start nonzero without a match");

  a_start_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && text_start_i |=> idx_q == INDEX_WIDTH'(1))
    else $error("byte index not restarted by text_start");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item accepted while result is stalled");

  a_match_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && matched_d |=> prefix_q != '0)
    else $error("match reported with empty automaton state");

endmodule

FILE: tb/automaton_string_matcher_tb.sv
// Self-checking testbench for automaton_string_matcher: directed and random text
// streams checked against a scoreboard that tracks pattern, prefix state and index.
// Depends on asm_pkg and the automaton_string_matcher RTL.
`timescale 1ns / 100ps

module automaton_string_matcher_tb
  import asm_pkg::*;
();

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 240;
  localparam int INDEX_W     = 16;

  typedef struct packed {
    logic                     matched;
    logic [MATCH_START_W-1:0] start;
  } match_t;

  class match_scoreboard;
    byte_t              pattern[PAT_BYTES];
    logic [LEN_W-1:0]   length_reg;
    logic [LEN_W-1:0]   prefix_len;
    logic [INDEX_W-1:0] text_index;
    match_t             expected_q[$];
    int                 errors;

    function new();
      foreach (pattern[i]) pattern[i] = '0;
      length_reg = 1;
      prefix_len = 0;
      text_index = 0;
      errors     = 0;
    endfunction

    function int active_len();
      int l = length_reg;
      if (l < 1) l = 1;
      if (l > PAT_BYTES) l = PAT_BYTES;
      return l;
    endfunction

    function byte_t pattern_byte(int p);
      return pattern[p % PAT_BYTES];
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_PAT_LO: begin
          for (int i = 0; i < 8; i++) pattern[i] = d[8*i +: 8];
        end
        CFG_PAT_HI: begin
          for (int i = 0; i < 8; i++) pattern[8+i] = d[8*i +: 8];
        end
        CFG_PAT_LEN: length_reg = d[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // pattern[0..k-1] is a suffix of pattern[0..q-1] followed by c
    function bit suffix_fits(int k, int q, byte_t c);
      if (k == 0) return 1'b1;
      if (pattern[k-1] != c) return 1'b0;
      for (int j = 0; j + 1 < k; j++) begin
        if (pattern[j] != pattern[(q + 1 + j - k) % PAT_BYTES]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(byte_t c, logic start);
      int     l;
      int     q;
      int     k;
      int     cur;
      match_t want;
      l = active_len();
      if (start) begin
        prefix_len = 0;
        text_index = 0;
      end
      q = prefix_len;
      if (q > l) q = l;
      k = (q + 1 < l) ? q + 1 : l;
      while (!suffix_fits(k, q, c)) k--;
      prefix_len = LEN_W'(k);
      cur = text_index;
      if (text_index != {INDEX_W{1'b1}}) text_index = text_index + 1'b1;
      want = '0;
      if (k == l) begin
        want.matched = 1'b1;
        want.start   = (cur + 1 >= l) ? MATCH_START_W'(cur + 1 - l) : '0;
      end
      expected_q = {expected_q, want};
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic m, logic [MATCH_START_W-1:0] s);
      match_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no item pending (matched %0b, start %0d)", m, s));
        return;
      end
      want = expected_q.pop_front();
      if (m !== want.matched) report($sformatf("matched %0b, want %0b", m, want.matched));
      if (s !== want.start) report($sformatf("match_start %0d, want %0d", s, want.start));
    endtask

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_idx_e                 cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  byte_t                    text_byte;
  logic                     text_start;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     matched;
  logic [MATCH_START_W-1:0] match_start;

  match_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              stall_left = 0;
  int              cycle_count = 0;

  automaton_string_matcher DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .text_byte_i  (text_byte),
    .text_start_i (text_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .matched_o    (matched),
    .match_start_o(match_start)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [8*PAT_BYTES-1:0] gen_pattern();
    byte_t                 sym[3];
    int                    n;
    logic [8*PAT_BYTES-1:0] p;
    foreach (sym[i]) sym[i] = byte_t'($urandom);
    n = $urandom_range(1, 3);
    for (int i = 0; i < PAT_BYTES; i++)
      p[8*i +: 8] = ($urandom_range(0, 4) == 0) ? byte_t'($urandom) : sym[$urandom_range(0, n-1)];
    return p;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // check accepted results and toggle back-pressure
  always @(posedge clk) begin : result_side
    int g;
    if (rst_n && out_valid && out_ready) sb.check_result(matched, match_start);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      g = idle_gap();
      if (g > 0) begin
        out_ready  <= 1'b0;
        stall_left = g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_text(byte_t b, logic s);
    int gap = quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    text_start <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_item(b, s);
  endtask

  // drain all results, then allow the output register to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_put(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic write_pattern(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                               logic [LEN_W-1:0] len);
    cfg_put(CFG_PAT_LO, lo);
    cfg_put(CFG_PAT_HI, hi);
    cfg_put(CFG_PAT_LEN, CFG_DATA_W'(len));
    cfg_valid <= 1'b0;
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    cfg_put(CFG_PAT_LEN, CFG_DATA_W'(len));
    cfg_valid <= 1'b0;
  endtask

  // text built mostly from pattern prefixes, some corrupted, plus loose bytes
  task automatic random_text(int n, bit starts);
    int    sent = 0;
    int    sel;
    int    l;
    int    m;
    byte_t b;
    while (sent < n) begin
      l   = sb.active_len();
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        m = ($urandom_range(0, 2) == 0) ? $urandom_range(1, l) : l;
        for (int i = 0; i < m && sent < n; i++) begin
          b = sb.pattern_byte(i);
          if (i == m - 1 && $urandom_range(0, 9) == 0) b = byte_t'($urandom);
          send_text(b, starts && i == 0 && $urandom_range(0, 19) == 0);
          sent++;
        end
      end else begin
        b = (sel < 85) ? sb.pattern_byte($urandom_range(0, l - 1)) : byte_t'($urandom);
        send_text(b, starts && $urandom_range(0, 49) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [8*PAT_BYTES-1:0] pat;
    logic [LEN_W-1:0]       len;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_PAT_LO;
    cfg_data   = '0;
    in_valid   = 1'b0;
    text_byte  = '0;
    text_start = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pattern is a single zero byte; first text has no start mark
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    wait_idle();

    // overlapping matches of "aba"
    write_pattern(64'h6261626162616261, 64'h6261626162616261, 5'd3);
    send_text("a", 1'b1);
    send_text("b", 1'b0);
    send_text("a", 1'b0);
    send_text("b", 1'b0);
    send_text("a", 1'b0);
    wait_idle();

    // zero length acts as one
    write_length(5'd0);
    send_text("a", 1'b0);
    send_text("c", 1'b0);
    wait_idle();

    // oversized length acts as the full pattern
    write_pattern('1, '1, 5'd31);
    for (int i = 0; i < 17; i++) send_text(8'hFF, i == 0);
    wait_idle();

    // shrink the length mid-text with the state above it
    write_length(5'd2);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      pat = gen_pattern();
      case (p)
        0: len = 5'd1;
        1: begin
          pat = '1;
          len = 5'd16;
        end
        2: begin
          pat = '0;
          len = 5'd31;
        end
        3: len = 5'd0;
        4: len = 5'd17;
        default: len = LEN_W'($urandom_range(2, 15));
      endcase
      quiet = (p == 5);
      write_pattern(pat[63:0], pat[127:64], len);
      random_text(PHASE_ITEMS, 1'b1);
    end

    wait_idle();
    sb.flush_check();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
